>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define BDA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> sv/bda_pkg.sv
// ----------------------------------------------------------------------------
// bda_pkg
// Types and constants shared by the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package bda_pkg;

    localparam int VALUE_W     = 32;
    localparam int DIGIT_W     = 4;
    localparam int CHAR_W      = 6;
    localparam int RECIP_SHIFT = 35;

    // ceil(2^35 / 10): q = (v * RECIP_10) >> 35 equals v / 10 for any 32-bit v.
    localparam logic [VALUE_W-1:0] RECIP_10   = 32'hCCCC_CCCD;
    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;

    typedef struct packed {
        logic load;   // capture a new value and clear the digit count
        logic step;   // divide by ten and push the remainder digit
        logic pop;    // drop the digit that was just delivered
    } t_dp_cmd;

    typedef struct packed {
        logic quot_zero;   // the current division leaves a zero quotient
        logic full;        // this push fills the digit stack
        logic last_digit;  // exactly one digit remains on the stack
    } t_dp_status;

endpackage

>>> sv/bda_in_if.sv
// ----------------------------------------------------------------------------
// bda_in_if
// Valid/ready channel that carries one binary value per transaction.
// ----------------------------------------------------------------------------
interface bda_in_if
    import bda_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

>>> sv/bda_out_if.sv
// ----------------------------------------------------------------------------
// bda_out_if
// Valid/ready channel that carries one ASCII digit per transaction.
// ----------------------------------------------------------------------------
interface bda_out_if
    import bda_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] digit_char;
    logic              last;

    modport source (output valid, output digit_char, output last, input ready);
    modport sink   (input valid, input digit_char, input last, output ready);
endinterface

>>> sv/bda_datapath.sv
// ----------------------------------------------------------------------------
// bda_datapath
// Divide-by-ten unit and digit stack of the decimal converter.
// ----------------------------------------------------------------------------
module bda_datapath
    import bda_pkg::*;
#(
    parameter int MAX_DIGITS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [VALUE_W-1:0] i_value,
    output t_dp_status         o_status,
    output logic [CHAR_W-1:0]  o_digit_char,
    output logic               o_last
);
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    logic [VALUE_W-1:0]   r_val;
    logic [DIGIT_W-1:0]   r_stack [MAX_DIGITS];
    logic [CNT_W-1:0]     r_count;

    logic [2*VALUE_W-1:0] w_prod;
    logic [VALUE_W-1:0]   w_quot;
    logic [VALUE_W-1:0]   w_quot_x10;
    logic [VALUE_W-1:0]   w_rem;
    logic [DIGIT_W-1:0]   w_digit;

    // Reciprocal multiply gives the quotient; the remainder is v - 10q.
    assign w_prod     = {{VALUE_W{1'b0}}, r_val} * {{VALUE_W{1'b0}}, RECIP_10};
    assign w_quot     = VALUE_W'(w_prod >> RECIP_SHIFT);
    assign w_quot_x10 = (w_quot << 3) + (w_quot << 1);
    assign w_rem      = r_val - w_quot_x10;
    assign w_digit    = w_rem[DIGIT_W-1:0];

    // Digits are pushed least significant first, so the top of the stack
    // holds the most significant digit once the division chain ends.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val <= i_value;
        end else if (i_cmd.step) begin
            r_val      <= w_quot;
            r_stack[0] <= w_digit;
            for (int i = 1; i < MAX_DIGITS; i++) begin
                r_stack[i] <= r_stack[i-1];
            end
        end else if (i_cmd.pop) begin
            for (int i = 0; i < MAX_DIGITS - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_count <= '0;
        end else if (i_cmd.step) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.pop) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    assign o_status.quot_zero  = (w_quot == '0);
    assign o_status.full       = (r_count == CNT_W'(MAX_DIGITS - 1));
    assign o_status.last_digit = (r_count == CNT_W'(1));

    assign o_digit_char = ASCII_ZERO + CHAR_W'(r_stack[0]);
    assign o_last       = o_status.last_digit;
endmodule

>>> sv/bda_controller.sv
// ----------------------------------------------------------------------------
// bda_controller
// Sequencer that loads a value, runs the division chain and drains digits.
// ----------------------------------------------------------------------------
module bda_controller
    import bda_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);
    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

    assign o_cmd.load = i_in_valid && r_in_ready;
    assign o_cmd.step = (r_state == S_CONV);
    assign o_cmd.pop  = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && r_in_ready) begin
                        r_state    <= S_CONV;
                        r_in_ready <= 1'b0;
                    end
                end
                // A zero value still takes one step and yields the digit zero.
                S_CONV: begin
                    if (i_status.quot_zero || i_status.full) begin
                        r_state     <= S_EMIT;
                        r_out_valid <= 1'b1;
                    end
                end
                S_EMIT: begin
                    if (i_out_ready && i_status.last_digit) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b0;
                        r_in_ready  <= 1'b1;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b0;
                    r_in_ready  <= 1'b1;
                end
            endcase
        end
    end
endmodule

>>> sv/binary_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core
// Converts 32-bit unsigned values to decimal ASCII digits, one per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one 32-bit value per transaction. o_out returns its decimal
//   digits, most significant first, without leading zeros; last marks the
//   final digit. A value of zero gives the single digit '0'.
//   One value is handled at a time. After a value is accepted, a shared
//   reciprocal-multiply divide-by-ten unit produces one digit per cycle. The
//   first digit is valid on the next cycle after the last division step, and
//   the digits drain at one per cycle while the receiver is ready.
//   A stall on o_out holds the current digit and its flag; i_in stays not
//   ready until the last digit of the current value has been taken.
//   Reset (synchronous, active low) returns to idle with i_in ready and
//   o_out empty; any conversion in progress is dropped.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_core
    import bda_pkg::*;
#(
    parameter int MAX_DIGITS = 10
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bda_in_if.sink    i_in,
    bda_out_if.source o_out
);
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    bda_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    bda_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_value      (i_in.value),
        .o_status     (w_status),
        .o_digit_char (o_out.digit_char),
        .o_last       (o_out.last)
    );
endmodule

>>> sv/bda_checker.sv
// ----------------------------------------------------------------------------
// bda_checker
// Port-level checks of the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bda_checker
    import bda_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [CHAR_W-1:0] i_digit_char,
    input logic              i_last
);
    logic r_first;

    // Set while the next digit on the output is the first of a number.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (i_out_valid && i_out_ready) begin
            r_first <= i_last;
        end
    end

    `BDA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_digit_char) && $stable(i_last))

    `BDA_ASSERT_IMP(a_one_item, i_clk, i_rst_n, i_out_valid, !i_in_ready)

    `BDA_ASSERT_NXT(a_conv_gap, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_out_valid)

    `BDA_ASSERT_IMP(a_no_lead_zero, i_clk, i_rst_n, i_out_valid && r_first && !i_last, i_digit_char != ASCII_ZERO)
endmodule

bind binary_to_decimal_ascii_core bda_checker u_bda_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_digit_char (o_out.digit_char),
    .i_last       (o_out.last)
);

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binary to decimal ASCII converter. Values go in
// on the input channel. Each accepted value is turned into its expected digit
// transactions by a behavioral divide-by-ten predictor. The digit channel is
// compared in order, one field at a time. Both channels see random idle
// bursts, except in the closing back-to-back phase.
// ----------------------------------------------------------------------------
module tb_top;
    import bda_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int MAX_DIGITS   = 10;
    localparam int QUIET_LIMIT  = 1000;
    localparam int SETTLE_TICKS = 30;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
    } t_ascii_digit;

    logic clk;
    logic rst_n;

    bda_in_if  in_ch ();
    bda_out_if out_ch ();

    t_ascii_digit pending_digits[$];
    int           mismatch_count;
    bit           send_gaps_on;
    bit           recv_stalls_on;
    int           quiet_cycles;

    binary_to_decimal_ascii_core #(
        .MAX_DIGITS(MAX_DIGITS)
    ) DUT (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Expected digits of one value, most significant first.
    function automatic void push_decimal_digits(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] rest;
        logic [DIGIT_W-1:0] rev_digits [MAX_DIGITS];
        int                 count;
        t_ascii_digit       entry;
        rest  = value;
        count = 0;
        do begin
            rev_digits[count] = DIGIT_W'(rest % 10);
            rest              = rest / 10;
            count++;
        end while (rest != 0 && count < MAX_DIGITS);
        for (int k = count - 1; k >= 0; k--) begin
            entry.digit_char = ASCII_ZERO + CHAR_W'(rev_digits[k]);
            entry.last       = (k == 0);
            pending_digits.push_back(entry);
        end
    endfunction

    function automatic logic [VALUE_W-1:0] random_value_of_length(input int num_digits);
        longint unsigned lo;
        longint unsigned hi;
        lo = (num_digits == 1) ? 0 : 1;
        for (int k = 1; k < num_digits; k++) lo = lo * 10;
        hi = (num_digits == 1) ? 9 : lo * 10 - 1;
        if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
        return $urandom_range(int'(hi), int'(lo));
    endfunction

    // Leaves valid high after the transaction so back-to-back values need no
    // second assignment in one time step.
    task automatic send_value(input logic [VALUE_W-1:0] value);
        if (send_gaps_on && $urandom_range(0, 2) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= value;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        push_decimal_digits(value);
    endtask

    task automatic wait_for_drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_digits.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed_values();
        logic [VALUE_W-1:0] corner_values[$];
        corner_values = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999,
                          32'd1000, 32'd99999, 32'd100000, 32'd999999999,
                          32'd1000000000, 32'd1234567890, 32'h8000_0000,
                          32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFE,
                          32'hFFFF_FFFF};
        foreach (corner_values[k]) send_value(corner_values[k]);
    endtask

    // Every decimal length is equally likely, with some full-range values.
    task automatic test_random_lengths(input int num_items);
        for (int k = 0; k < num_items; k++) begin
            if (k % 20 == 0) begin
                send_gaps_on   = $urandom_range(0, 1);
                recv_stalls_on = $urandom_range(0, 1);
            end
            if ($urandom_range(0, 4) == 0) send_value($urandom());
            else send_value(random_value_of_length($urandom_range(1, 10)));
        end
    endtask

    task automatic test_drain_pause();
        send_gaps_on   = 1'b1;
        recv_stalls_on = 1'b1;
        repeat (4) send_value(random_value_of_length($urandom_range(1, 10)));
        wait_for_drain();
        send_value(32'hFFFF_FFFF);
        send_value(32'd0);
        wait_for_drain();
        send_value(32'd7);
    endtask

    task automatic test_back_to_back(input int num_items);
        send_gaps_on   = 1'b0;
        recv_stalls_on = 1'b0;
        repeat (num_items) send_value(random_value_of_length($urandom_range(1, 10)));
        in_ch.valid <= 1'b0;
    endtask

    // Receiver stalls.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (recv_stalls_on && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        t_ascii_digit want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_digits.size() == 0) begin
                $display("%0t: unexpected digit transaction: expected none, actual char %0d last %0b",
                         $time, out_ch.digit_char, out_ch.last);
                mismatch_count++;
            end else begin
                want = pending_digits.pop_front();
                if (out_ch.digit_char !== want.digit_char) begin
                    $display("%0t: digit_char mismatch: expected %0d, actual %0d",
                             $time, want.digit_char, out_ch.digit_char);
                    mismatch_count++;
                end
                if (out_ch.last !== want.last) begin
                    $display("%0t: last mismatch: expected %0b, actual %0b",
                             $time, want.last, out_ch.last);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run if neither channel moves for too long.
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("** binary_to_decimal_ascii_core: FAILED **");
        $finish;
    end

    initial begin
        mismatch_count = 0;
        send_gaps_on   = 1'b1;
        recv_stalls_on = 1'b1;
        rst_n          <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.value    <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_values();
        test_drain_pause();
        test_random_lengths(75);
        test_back_to_back(20);

        while (pending_digits.size() != 0) @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
        if (mismatch_count == 0 && pending_digits.size() == 0) begin
            $display("** binary_to_decimal_ascii_core: PASSED **");
        end else begin
            $display("** binary_to_decimal_ascii_core: FAILED **");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+sv
sv/bda_pkg.sv
sv/bda_in_if.sv
sv/bda_out_if.sv
sv/bda_datapath.sv
sv/bda_controller.sv
sv/binary_to_decimal_ascii_core.sv
sv/bda_checker.sv
sim/tb_top.sv
